@@ rtl/lsef_pkg.sv @@
`timescale 1ns / 1ps

package lsef_pkg;

    localparam int NUM_CH      = 8;
    localparam int ERR_W       = 15;
    localparam int JUMP_W      = 15;
    localparam int ACT_W       = 4;
    localparam int TRANS_W     = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 15;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACTIVE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRANSITIONS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_LIMIT      = 2'd2;

    localparam logic [ACT_W-1:0]   RST_MAX_ACTIVE      = 4'd3;
    localparam logic [TRANS_W-1:0] RST_MAX_TRANSITIONS = 3'd2;
    localparam logic [JUMP_W-1:0]  RST_JUMP_LIMIT      = 15'd6400;

    typedef enum logic [1:0] {
        ST_ACCEPT  = 2'd0,
        ST_PATTERN = 2'd1,
        ST_JUMP    = 2'd2,
        ST_LOST    = 2'd3
    } t_status;

    typedef logic signed [6:0] t_weight;
    localparam t_weight SENSOR_WEIGHT [NUM_CH] = '{
        -7'sd40, -7'sd30, -7'sd20, -7'sd10, 7'sd10, 7'sd20, 7'sd30, 7'sd40
    };

    // controller -> datapath
    typedef struct packed {
        logic load;      // input transfer: update stable bits
        logic eval;      // classify pattern, load divider
        logic div_step;  // one radix-4 divide step
        logic finish;    // jump check, write result register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_div;  // pattern plausible and at least one sensor active
    } t_dp_status;

endpackage

@@ rtl/lsef_in_if.sv @@
`timescale 1ns / 1ps

interface lsef_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] first_sample;
    logic [7:0] second_sample;

    modport source (output valid, output first_sample, output second_sample, input ready);
    modport sink   (input valid, input first_sample, input second_sample, output ready);
endinterface

@@ rtl/lsef_out_if.sv @@
`timescale 1ns / 1ps

interface lsef_out_if;
    import lsef_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [ERR_W-1:0] error_value;
    logic [1:0]              status;

    modport source (output valid, output error_value, output status, input ready);
    modport sink   (input valid, input error_value, input status, output ready);
endinterface

@@ rtl/lsef_cfg_if.sv @@
`timescale 1ns / 1ps

interface lsef_cfg_if;
    import lsef_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/line_sensor_error_filter.sv @@
`timescale 1ns / 1ps

// Line position error from eight line sensors. Each input transfer brings two
// reads of the sensors; a channel's stable bit follows the reads only where
// both agree. The result is the mean of the weights -40..40 over the active
// channels, signed with 8 fraction bits, truncated toward zero, with status
// 0 accepted, 1 pattern rejected (too many active sensors or neighbor
// changes), 2 jump rejected (change from the held error above jump_limit),
// 3 line lost (no active sensor). Every status but 0 reports the held error.
// One item at a time: a plausible pattern goes from input transfer through
// accept, evaluate, 8 steps of the radix-4 divider by the active count and
// the jump check; rejected or lost patterns skip the divider steps.
// The next item is taken in the cycle after the result register is written;
// a result waiting on the output does not stall the next item until its own
// result is ready. Configuration writes are always taken.

module line_sensor_error_filter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lsef_in_if.sink    i_item,
    lsef_out_if.source o_result,
    lsef_cfg_if.sink   i_cfg
);
    import lsef_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status dp_status;

    // sequencer: accept, evaluate, divide, finish
    lsef_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (cmd),
        .i_status    (dp_status)
    );

    // stable bits, held error, config registers, divider, result register
    lsef_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (dp_status),
        .i_first_sample  (i_item.first_sample),
        .i_second_sample (i_item.second_sample),
        .i_cfg           (i_cfg),
        .o_error_value   (o_result.error_value),
        .o_result_status (o_result.status)
    );

endmodule

@@ rtl/lsef_datapath.sv @@
`timescale 1ns / 1ps

module lsef_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lsef_pkg::t_dp_cmd               i_cmd,
    output lsef_pkg::t_dp_status            o_status,
    input  logic [7:0]                      i_first_sample,
    input  logic [7:0]                      i_second_sample,
    lsef_cfg_if.sink                        i_cfg,
    output logic signed [lsef_pkg::ERR_W-1:0] o_error_value,
    output logic [1:0]                      o_result_status
);
    import lsef_pkg::*;

    logic [ACT_W-1:0]        r_max_active;
    logic [TRANS_W-1:0]      r_max_trans;
    logic [JUMP_W-1:0]       r_jump_limit;

    logic [NUM_CH-1:0]       r_stable;
    logic signed [ERR_W-1:0] r_held;

    t_status                 r_code;
    logic                    r_neg;
    logic [ACT_W-1:0]        r_div;
    logic [2:0]              r_rem;
    logic [15:0]             r_quo;

    logic signed [ERR_W-1:0] r_out_err;
    t_status                 r_out_status;

    logic [NUM_CH-1:0]       agree;
    logic [ACT_W-1:0]        active;
    logic [TRANS_W-1:0]      trans;
    logic signed [7:0]       sum;
    logic [6:0]              sum_mag;
    logic                    pattern_bad;
    logic [2:0]              n_rem;
    logic [15:0]             n_quo;
    logic signed [15:0]      err;
    logic signed [16:0]      delta;
    logic [16:0]             delta_mag;
    logic                    jump_bad;

    assign i_cfg.ready = 1'b1;
    assign agree = ~(i_first_sample ^ i_second_sample);

    // population count, neighbor changes and weight sum of the stable bits
    always_comb begin
        active = '0;
        trans  = '0;
        sum    = '0;
        for (int i = 0; i < NUM_CH; i++) begin
            if (r_stable[i]) begin
                active = active + 1'b1;
                sum    = sum + 8'(SENSOR_WEIGHT[i]);
            end
            if (i < NUM_CH - 1) begin
                if (r_stable[i] != r_stable[(i + 1) % NUM_CH]) begin
                    trans = trans + 1'b1;
                end
            end
        end
        sum_mag     = sum[7] ? 7'(-sum) : sum[6:0];
        pattern_bad = (trans > r_max_trans) || (active > r_max_active);
        o_status.need_div = !pattern_bad && (active != '0);
    end

    // two restoring steps per cycle; remainder stays below the divisor (<= 8)
    always_comb begin
        logic [3:0] t;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int s = 0; s < 2; s++) begin
            t     = {n_rem, n_quo[15]};
            n_quo = {n_quo[14:0], 1'b0};
            if (t >= r_div) begin
                t        = t - r_div;
                n_quo[0] = 1'b1;
            end
            n_rem = t[2:0];
        end
    end

    always_comb begin
        err       = r_neg ? -$signed(r_quo) : $signed(r_quo);
        delta     = 17'(err) - 17'(r_held);
        delta_mag = delta[16] ? 17'(-delta) : 17'(delta);
        jump_bad  = delta_mag > {2'b00, r_jump_limit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_active <= RST_MAX_ACTIVE;
            r_max_trans  <= RST_MAX_TRANSITIONS;
            r_jump_limit <= RST_JUMP_LIMIT;
            r_stable     <= '0;
            r_held       <= '0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_MAX_ACTIVE:      r_max_active <= i_cfg.data[ACT_W-1:0];
                    CFG_MAX_TRANSITIONS: r_max_trans  <= i_cfg.data[TRANS_W-1:0];
                    CFG_JUMP_LIMIT:      r_jump_limit <= i_cfg.data[JUMP_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_stable <= (r_stable & ~agree) | (i_first_sample & agree);
            end
            if (i_cmd.finish && r_code == ST_ACCEPT && !jump_bad) begin
                r_held <= err[ERR_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_code <= pattern_bad ? ST_PATTERN : (active == '0) ? ST_LOST : ST_ACCEPT;
            r_neg  <= sum[7];
            r_div  <= active;
            r_rem  <= '0;
            r_quo  <= {1'b0, sum_mag, 8'h00};
        end else if (i_cmd.div_step) begin
            r_rem  <= n_rem;
            r_quo  <= n_quo;
        end
        if (i_cmd.finish) begin
            if (r_code != ST_ACCEPT) begin
                r_out_err    <= r_held;
                r_out_status <= r_code;
            end else if (jump_bad) begin
                r_out_err    <= r_held;
                r_out_status <= ST_JUMP;
            end else begin
                r_out_err    <= err[ERR_W-1:0];
                r_out_status <= ST_ACCEPT;
            end
        end
    end

    assign o_error_value   = r_out_err;
    assign o_result_status = r_out_status;

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_div != '0))
        else $error("divide step with zero divisor");

    a_held_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (r_out_status != ST_ACCEPT || r_held == r_out_err))
        else $error("accepted error not held");

    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (r_out_err <= 15'sd10240 && r_out_err >= -15'sd10240))
        else $error("error out of range");

endmodule

@@ rtl/lsef_ctrl.sv @@
`timescale 1ns / 1ps

module lsef_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output lsef_pkg::t_dp_cmd    o_cmd,
    input  lsef_pkg::t_dp_status i_status
);
    import lsef_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_FINISH
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_step, n_step;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        o_in_ready      = (r_state == S_IDLE);
        o_cmd.load      = (r_state == S_IDLE) && i_in_valid;
        o_cmd.eval      = (r_state == S_EVAL);
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.finish    = (r_state == S_FINISH) && (!r_out_valid || i_out_ready);

        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EVAL;
            end
            S_EVAL: begin
                n_step  = '0;
                n_state = i_status.need_div ? S_DIV : S_FINISH;
            end
            S_DIV: begin
                n_step = r_step + 1'b1;
                if (r_step == '1) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (o_cmd.finish) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_accept_to_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_EVAL))
        else $error("transfer not followed by evaluation");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");

    a_finish_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished result not presented");

endmodule
